// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== rtl/core/bol_pkg.sv =====
// ---------------------------------------------------------------------------
// bol_pkg
// types and constants of the bounded ordered list
// ---------------------------------------------------------------------------
`default_nettype none

package bol_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CNT_OUT_W = 5;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_BACK  = 3'd1,
    K_INSERT     = 3'd2,
    K_POP_FRONT  = 3'd3,
    K_POP_BACK   = 3'd4,
    K_REMOVE     = 3'd5,
    K_SEARCH     = 3'd6
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic cap;
    logic cmp;
    logic apply;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bol_req_if.sv =====
// ---------------------------------------------------------------------------
// bol_req_if
// request channel: operation kind and value
// ---------------------------------------------------------------------------
`default_nettype none

interface bol_req_if;
  import bol_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, kind, item_value, input ready);
  modport sink   (input valid, kind, item_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bol_rsp_if.sv =====
// ---------------------------------------------------------------------------
// bol_rsp_if
// response channel: status, removed value, match flag and entry count
// ---------------------------------------------------------------------------
`default_nettype none

interface bol_rsp_if;
  import bol_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] removed_value;
  logic                     found;
  logic [CNT_OUT_W-1:0]     entry_count;

  modport source (output valid, status, removed_value, found, entry_count, input ready);
  modport sink   (input valid, status, removed_value, found, entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bounded_ordered_list_top.sv =====
// ---------------------------------------------------------------------------
// bounded_ordered_list_top
// ordered list of up to DEPTH signed words with push, pop, insert, remove, search
// ---------------------------------------------------------------------------
// request flow: capture, parallel compare, shift; the response register is loaded with the shift
// a new request is taken only when the sequencer is back in idle, after the previous shift
// a pending response does not block the next request; apply waits for it
// reset: asynchronous active low, list emptied at once, no clearing pass
`default_nettype none

module bounded_ordered_list_top #(
  parameter int unsigned DEPTH = bol_pkg::DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bol_req_if.sink   req_i,
  bol_rsp_if.source rsp_o
);
  import bol_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  bol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  bol_dp #(.DEPTH(DEPTH)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (req_i.kind),
    .item_value_i    (req_i.item_value),
    .status_o        (rsp_o.status),
    .removed_value_o (rsp_o.removed_value),
    .found_o         (rsp_o.found),
    .entry_count_o   (rsp_o.entry_count)
  );

endmodule

`default_nettype wire

// ===== rtl/core/bol_ctrl.sv =====
// ---------------------------------------------------------------------------
// bol_ctrl
// sequencer: capture request, compare all cells, apply and post response
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bol_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  wire logic          rsp_ready_i,
  output bol_pkg::ctl_cmd_t  cmd_o,
  input  wire bol_pkg::dp_stat_t stat_i
);
  import bol_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    out_valid_d = out_valid_q && !rsp_ready_i;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = S_APPLY;
      end
      S_APPLY: begin
        // wait until the output register is free
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.apply = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rsp_valid_o = out_valid_q;

  `ASSERT_CLK(a_apply_posts, cmd_o.apply |=> rsp_valid_o)
  `ASSERT_CLK(a_cap_then_cmp, cmd_o.cap |=> cmd_o.cmp)
  `ASSERT_NEVER(a_full_and_empty, stat_i.full && stat_i.empty)

endmodule

`default_nettype wire

// ===== rtl/core/bol_dp.sv =====
// ---------------------------------------------------------------------------
// bol_dp
// row of entry cells with per-cell compare, shift network and response register
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bol_dp #(
  parameter int unsigned DEPTH = bol_pkg::DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire bol_pkg::ctl_cmd_t                cmd_i,
  output bol_pkg::dp_stat_t                     stat_o,
  input  wire logic [bol_pkg::KIND_W-1:0]       kind_i,
  input  wire logic signed [bol_pkg::DATA_W-1:0] item_value_i,
  output logic [bol_pkg::STAT_W-1:0]            status_o,
  output logic signed [bol_pkg::DATA_W-1:0]     removed_value_o,
  output logic                                  found_o,
  output logic [bol_pkg::CNT_OUT_W-1:0]         entry_count_o
);
  import bol_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  logic signed [DATA_W-1:0] ent_q [DEPTH];
  logic [CW-1:0]            count_q, count_d;
  logic [KIND_W-1:0]        kind_q;
  logic signed [DATA_W-1:0] val_q;
  logic [DEPTH-1:0]         ord_q, eq_q;

  logic                     full, empty;
  logic [CW-1:0]            ord_pos, eq_pos, cnt_m1;
  logic                     hit;
  logic                     ins_en, rem_en;
  logic [IW-1:0]            pos;
  logic [STAT_W-1:0]        status_d;
  logic signed [DATA_W-1:0] removed_d;
  logic                     found_d;
  logic [CW+CNT_OUT_W-1:0]  cnt_ext;

  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);
  assign cnt_m1 = count_q - 1'b1;
  assign stat_o = '{full: full, empty: empty};

  // request capture and per-cell compare flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      kind_q <= kind_i;
      val_q  <= item_value_i;
    end
    if (cmd_i.cmp) begin
      for (int k = 0; k < DEPTH; k++) begin
        eq_q[k] <= (CW'(k) < count_q) && (ent_q[k] == val_q);
        if (k == 0) begin
          ord_q[k] <= empty || (val_q < ent_q[0]);
        end else begin
          ord_q[k] <= (CW'(k) < count_q) && !(ent_q[k] < val_q);
        end
      end
    end
  end

  // first set flag: order position, or the count when none; match position with hit
  always_comb begin
    ord_pos = count_q;
    eq_pos  = '0;
    hit     = 1'b0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (ord_q[k]) ord_pos = CW'(k);
      if (eq_q[k]) begin
        eq_pos = CW'(k);
        hit    = 1'b1;
      end
    end
  end

  always_comb begin
    ins_en    = 1'b0;
    rem_en    = 1'b0;
    pos       = '0;
    status_d  = ST_DONE;
    removed_d = '0;
    found_d   = 1'b0;
    count_d   = count_q;
    unique case (kind_e'(kind_q)) inside
      K_PUSH_FRONT, K_PUSH_BACK, K_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ins_en  = 1'b1;
          count_d = count_q + 1'b1;
          if (kind_e'(kind_q) == K_PUSH_BACK) pos = count_q[IW-1:0];
          else if (kind_e'(kind_q) == K_INSERT) pos = ord_pos[IW-1:0];
        end
      end
      K_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          removed_d = ent_q[0];
          rem_en    = 1'b1;
          count_d   = cnt_m1;
        end
      end
      K_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          removed_d = ent_q[cnt_m1[IW-1:0]];
          count_d   = cnt_m1;
        end
      end
      K_REMOVE: begin
        if (hit) begin
          removed_d = ent_q[eq_pos[IW-1:0]];
          found_d   = 1'b1;
          rem_en    = 1'b1;
          pos       = eq_pos[IW-1:0];
          count_d   = cnt_m1;
        end else begin
          status_d = ST_EMPTY;
        end
      end
      K_SEARCH: begin
        if (hit) found_d = 1'b1;
        else status_d = ST_EMPTY;
      end
      default: ;
    endcase
  end

  // shift network: each cell takes its neighbor, takes the new value or holds
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      for (int k = 0; k < DEPTH; k++) begin
        if (ins_en) begin
          if (IW'(k) == pos) ent_q[k] <= val_q;
          else if (k > 0 && IW'(k) > pos) ent_q[k] <= ent_q[(k > 0) ? k - 1 : 0];
        end else if (rem_en) begin
          if (k < DEPTH - 1 && IW'(k) >= pos) ent_q[k] <= ent_q[(k < DEPTH - 1) ? k + 1 : k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.apply) begin
      count_q <= count_d;
    end
  end

  assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_d};

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      status_o        <= status_d;
      removed_value_o <= removed_d;
      found_o         <= found_d;
      entry_count_o   <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  `ASSERT_NEVER(a_count_range, count_q > CW'(DEPTH))
  `ASSERT_CLK(a_search_keeps, cmd_i.apply && kind_q == K_SEARCH |=> $stable(count_q))
  `ASSERT_NEVER(a_ins_and_rem, ins_en && rem_en)

endmodule

`default_nettype wire
